// ===== rtl/ipbl_pkg.sv =====
// ----------------------------------------------------------------------------
// ipbl_pkg: shared types and constants
// Rule and address record layouts, function codes, status codes, rule kinds, defaults and address helpers.
// ----------------------------------------------------------------------------
package ipbl_pkg;

  localparam int unsigned RuleSlotsDef = 16;
  localparam int unsigned AddrW = 64;
  localparam int unsigned PrefixW = 8;
  localparam logic [PrefixW-1:0] V4PrefixMax = 8'd32;
  localparam logic [PrefixW-1:0] V6PrefixMax = 8'd128;
  localparam logic [15:0] MappedTag = 16'hffff;

  typedef enum logic [2:0] {
    FUNC_CHECK  = 3'd0,
    FUNC_ADDR   = 3'd1,
    FUNC_RANGE  = 3'd2,
    FUNC_SUBNET = 3'd3,
    FUNC_REMOVE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ORDER  = 2'd2,
    STATUS_PREFIX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_ADDR   = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_SUBNET = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         fams;
    logic [AddrW-1:0]   first_hi;
    logic [AddrW-1:0]   first_lo;
    logic [AddrW-1:0]   second_hi;
    logic [AddrW-1:0]   second_lo;
    logic [PrefixW-1:0] prefix;
  } rule_t;

  localparam int unsigned RuleW = $bits(rule_t);

  typedef struct packed {
    logic             fam;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
  } addr_t;

  // Mask IPv4 down to its 32 bits
  function automatic addr_t norm_addr(logic fam, logic [AddrW-1:0] hi, logic [AddrW-1:0] lo);
    addr_t a;
    a.fam = fam;
    a.hi  = fam ? hi : '0;
    a.lo  = fam ? lo : {32'd0, lo[31:0]};
    return a;
  endfunction

  // 128-bit mapped form
  function automatic logic [127:0] map_addr(addr_t a);
    logic [127:0] m;
    m = {a.hi, a.lo};
    if (!a.fam) m[47:32] = MappedTag;
    return m;
  endfunction

  function automatic logic is_mapped(addr_t a);
    return (a.hi == '0) && (a.lo[63:32] == {16'd0, MappedTag});
  endfunction

endpackage

// ===== rtl/ipbl_ram.sv =====
// ----------------------------------------------------------------------------
// ipbl_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ipbl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ipbl_match.sv =====
// ----------------------------------------------------------------------------
// ipbl_match: shared rule compare unit
// Tests one stored rule against the key address; also flags removal hits.
// ----------------------------------------------------------------------------
module ipbl_match
  import ipbl_pkg::*;
(
  input  rule_t rule_i,
  input  addr_t key_i,
  output logic  hit_o,
  output logic  rm_hit_o
);

  addr_t        f, s;
  logic [127:0] xm, fm, sm, pmask;
  logic         nc1, nc2, ge1, le2;
  logic [7:0]   n;
  logic [8:0]   n_w;

  always_comb begin
    f   = norm_addr(rule_i.fams[0], rule_i.first_hi, rule_i.first_lo);
    s   = norm_addr(rule_i.fams[1], rule_i.second_hi, rule_i.second_lo);
    xm  = map_addr(key_i);
    fm  = map_addr(f);
    sm  = map_addr(s);
    nc1 = (key_i.fam != f.fam) &&
          ((key_i.fam && !is_mapped(key_i)) || (f.fam && !is_mapped(f)));
    nc2 = (key_i.fam != s.fam) &&
          ((key_i.fam && !is_mapped(key_i)) || (s.fam && !is_mapped(s)));
    ge1 = !nc1 && (xm >= fm);
    le2 = !nc2 && (xm <= sm);
    // Prefix length over the mapped form, clamped to 128
    n_w = f.fam ? {1'b0, rule_i.prefix} : 9'd96 + {1'b0, rule_i.prefix};
    n   = (n_w > 9'd128) ? 8'd128 : n_w[7:0];
    pmask = (n == 8'd0) ? '0 : ~(128'd0) << (8'd128 - n);
    unique case (rule_i.kind)
      KIND_ADDR:   hit_o = (xm == fm);
      KIND_RANGE:  hit_o = ge1 && le2;
      KIND_SUBNET: hit_o = ((xm ^ fm) & pmask) == '0;
      default:     hit_o = 1'b0;
    endcase
    rm_hit_o = (rule_i.kind == KIND_ADDR) && (rule_i.fams[0] == key_i.fam) &&
               (f.hi == key_i.hi) && (f.lo == key_i.lo);
  end

endmodule

// ===== rtl/ip_address_block_list_matcher_unit.sv =====
// Sequence: an add, or any func that does not walk the table, goes straight to
// the result; a check tests rule after rule, oldest first, until a hit; a
// remove walks newest to oldest the same way and, on a hit, shifts each later
// rule down by a read and a write. Throughput: one beat at a time; new beats
// stall until the result is taken; the one compare unit tests rules singly.
// Reset: asynchronous, clears rule count and sequencer, not the rule RAM.
// ----------------------------------------------------------------------------
// ip_address_block_list_matcher_unit: IP block list matcher top level
// Sequencer that stores rules in a RAM and walks them for check and remove.
// ----------------------------------------------------------------------------
module ip_address_block_list_matcher_unit
  import ipbl_pkg::*;
#(
  parameter int unsigned RuleSlots = RuleSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic                 first_family_i,
  input  logic [AddrW-1:0]     first_hi_i,
  input  logic [AddrW-1:0]     first_lo_i,
  input  logic                 second_family_i,
  input  logic [AddrW-1:0]     second_hi_i,
  input  logic [AddrW-1:0]     second_lo_i,
  input  logic [PrefixW-1:0]   prefix_len_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 blocked_o,
  output logic [1:0]           status_o
);

  localparam int unsigned IdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1;
  localparam int unsigned CntW = $clog2(RuleSlots + 1);
  localparam logic [CntW-1:0] SlotsC = CntW'(RuleSlots);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_CMP   = 6'b000100,
    ST_MVRD  = 6'b001000,
    ST_MVWR  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  func_e          func_q, func_d;
  addr_t          key_q, key_d;
  logic           blocked_q, blocked_d;
  logic [1:0]     status_q, status_d;

  logic           we;
  logic [IdxW-1:0] waddr, raddr;
  rule_t          wdata, rdata;
  logic           hit, rm_hit;
  addr_t          fa, sa;
  logic           nc, gt;
  logic [127:0]   fm, sm;

  ipbl_ram #(.Width(RuleW), .Depth(RuleSlots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ipbl_match u_match (
    .rule_i   (rdata),
    .key_i    (key_q),
    .hit_o    (hit),
    .rm_hit_o (rm_hit)
  );

  // Insert checks on the incoming beat
  always_comb begin
    fa = norm_addr(first_family_i, first_hi_i, first_lo_i);
    sa = norm_addr(second_family_i, second_hi_i, second_lo_i);
    fm = map_addr(fa);
    sm = map_addr(sa);
    nc = (fa.fam != sa.fam) &&
         ((fa.fam && !is_mapped(fa)) || (sa.fam && !is_mapped(sa)));
    gt = !nc && (fm > sm);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign blocked_o   = blocked_q;
  assign status_o    = status_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    func_d    = func_q;
    key_d     = key_q;
    blocked_d = blocked_q;
    status_d  = status_q;
    we        = 1'b0;
    waddr     = count_q[IdxW-1:0];
    raddr     = idx_q[IdxW-1:0];
    wdata     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d     = fa;
          func_d    = func_e'(func_i);
          blocked_d = 1'b0;
          status_d  = STATUS_OK;
          state_d   = ST_OUT;
          wdata.fams     = {sa.fam, fa.fam};
          wdata.first_hi = fa.hi;
          wdata.first_lo = fa.lo;
          unique case (func_i)
            FUNC_CHECK: begin
              idx_d = '0;
              if (count_q != '0) state_d = ST_RD;
            end
            FUNC_REMOVE: begin
              // Walk from newest to oldest
              idx_d = count_q;
              if (count_q != '0) state_d = ST_RD;
            end
            FUNC_ADDR: begin
              wdata.kind = KIND_ADDR;
              wdata.fams = {1'b0, fa.fam};
              if (count_q >= SlotsC) status_d = STATUS_FULL;
              else begin
                we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            FUNC_RANGE: begin
              wdata.kind      = KIND_RANGE;
              wdata.second_hi = sa.hi;
              wdata.second_lo = sa.lo;
              if (gt) status_d = STATUS_ORDER;
              else if (count_q >= SlotsC) status_d = STATUS_FULL;
              else begin
                we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            FUNC_SUBNET: begin
              wdata.kind   = KIND_SUBNET;
              wdata.fams   = {1'b0, fa.fam};
              wdata.prefix = prefix_len_i;
              if (prefix_len_i > (fa.fam ? V6PrefixMax : V4PrefixMax))
                status_d = STATUS_PREFIX;
              else if (count_q >= SlotsC) status_d = STATUS_FULL;
              else begin
                we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        // Address the RAM; data arrives next cycle
        if (func_q == FUNC_REMOVE) begin
          idx_d = idx_q - 1'b1;
          raddr = idx_d[IdxW-1:0];
        end
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (func_q == FUNC_CHECK) begin
          if (hit) begin
            blocked_d = 1'b1;
            state_d   = ST_OUT;
          end else if (idx_q + 1'b1 >= count_q) state_d = ST_OUT;
          else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end else begin
          if (rm_hit) state_d = ST_MVRD;
          else if (idx_q == '0) state_d = ST_OUT;
          else state_d = ST_RD;
        end
      end
      ST_MVRD: begin
        // Read the next rule to shift down, or finish
        if (idx_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_OUT;
        end else begin
          raddr   = idx_q[IdxW-1:0] + 1'b1;
          state_d = ST_MVWR;
        end
      end
      ST_MVWR: begin
        we      = 1'b1;
        waddr   = idx_q[IdxW-1:0];
        wdata   = rdata;
        idx_d   = idx_q + 1'b1;
        state_d = ST_MVRD;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    key_q     <= key_d;
    blocked_q <= blocked_d;
    status_q  <= status_d;
  end

endmodule

// ===== tb/sv/ip_address_block_list_matcher_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_block_list_matcher_unit_test: self-checking block list bench
// Drives directed and random rule adds, removes and checks through the
// valid/stall channels, predicts blocked and status with a local rule table,
// and compares every result beat in order.
// ----------------------------------------------------------------------------
module ip_address_block_list_matcher_unit_test
  import ipbl_pkg::*;
();

  localparam int unsigned Slots = RuleSlotsDef;
  localparam int unsigned NumRandom = 1525;

  typedef enum int {
    CMP_LESS,
    CMP_EQUAL,
    CMP_GREATER,
    CMP_APART
  } order_e;

  typedef struct {
    logic [2:0]  func;
    logic        ffam;
    logic [63:0] fhi;
    logic [63:0] flo;
    logic        sfam;
    logic [63:0] shi;
    logic [63:0] slo;
    logic [7:0]  plen;
    logic        has_exp;
    logic        exp_blocked;
    status_e     exp_status;
  } cmd_t;

  typedef struct {
    logic    blocked;
    status_e status;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic        first_family_i;
  logic [63:0] first_hi_i;
  logic [63:0] first_lo_i;
  logic        second_family_i;
  logic [63:0] second_hi_i;
  logic [63:0] second_lo_i;
  logic [7:0]  prefix_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        blocked_o;
  logic [1:0]  status_o;

  // shadow rule table, oldest first
  int          rule_total;
  kind_e       tbl_kind [Slots];
  addr_t       tbl_first [Slots];
  addr_t       tbl_second [Slots];
  logic [7:0]  tbl_prefix [Slots];

  verdict_t    pending_verdicts[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  cmd_t        directed_rows[$];

  ip_address_block_list_matcher_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .first_family_i (first_family_i),
    .first_hi_i     (first_hi_i),
    .first_lo_i     (first_lo_i),
    .second_family_i(second_family_i),
    .second_hi_i    (second_hi_i),
    .second_lo_i    (second_lo_i),
    .prefix_len_i   (prefix_len_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blocked_o      (blocked_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic addr_t make_ip(logic fam, logic [63:0] hi, logic [63:0] lo);
    addr_t a;
    a.fam = fam;
    a.hi  = fam ? hi : 64'd0;
    a.lo  = fam ? lo : {32'd0, lo[31:0]};
    return a;
  endfunction

  function automatic logic [127:0] as_v6(addr_t a);
    logic [127:0] m;
    m = {a.hi, a.lo};
    if (!a.fam) m[47:32] = 16'hffff;
    return m;
  endfunction

  function automatic order_e order_of(addr_t a, addr_t b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic         a_map;
    logic         b_map;
    a_map = (a.hi == 64'd0) && (a.lo[63:32] == 32'h0000_ffff);
    b_map = (b.hi == 64'd0) && (b.lo[63:32] == 32'h0000_ffff);
    if (a.fam != b.fam && ((a.fam && !a_map) || (b.fam && !b_map))) return CMP_APART;
    ma = as_v6(a);
    mb = as_v6(b);
    if (ma < mb) return CMP_LESS;
    if (ma > mb) return CMP_GREATER;
    return CMP_EQUAL;
  endfunction

  function automatic logic rule_covers(int i, addr_t x);
    order_e        lo_ord;
    order_e        hi_ord;
    int            bits;
    logic [127:0]  mask;
    case (tbl_kind[i])
      KIND_ADDR: return as_v6(tbl_first[i]) == as_v6(x);
      KIND_RANGE: begin
        lo_ord = order_of(x, tbl_first[i]);
        hi_ord = order_of(x, tbl_second[i]);
        return (lo_ord == CMP_GREATER || lo_ord == CMP_EQUAL) &&
               (hi_ord == CMP_LESS || hi_ord == CMP_EQUAL);
      end
      KIND_SUBNET: begin
        bits = tbl_first[i].fam ? int'(tbl_prefix[i]) : 96 + int'(tbl_prefix[i]);
        if (bits > 128) bits = 128;
        mask = (bits == 0) ? 128'd0 : ~((128'd1 << (128 - bits)) - 128'd1);
        return ((as_v6(x) ^ as_v6(tbl_first[i])) & mask) == 128'd0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_rule(kind_e k, addr_t f, addr_t s, logic [7:0] p);
    tbl_kind[rule_total]   = k;
    tbl_first[rule_total]  = f;
    tbl_second[rule_total] = s;
    tbl_prefix[rule_total] = p;
    rule_total++;
  endfunction

  // append one row to the directed table
  function automatic void queue_row(cmd_t c);
    directed_rows = {directed_rows, c};
  endfunction

  // apply one command to the shadow table and return its verdict
  function automatic verdict_t block_list_verdict(cmd_t c);
    verdict_t v;
    addr_t    f;
    addr_t    s;
    addr_t    none;
    f = make_ip(c.ffam, c.fhi, c.flo);
    s = make_ip(c.sfam, c.shi, c.slo);
    none = make_ip(1'b0, 64'd0, 64'd0);
    v.blocked = 1'b0;
    v.status  = STATUS_OK;
    case (c.func)
      FUNC_CHECK: begin
        for (int i = 0; i < rule_total; i++) if (rule_covers(i, f)) v.blocked = 1'b1;
      end
      FUNC_ADDR: begin
        if (rule_total >= Slots) v.status = STATUS_FULL;
        else push_rule(KIND_ADDR, f, none, 8'd0);
      end
      FUNC_RANGE: begin
        if (order_of(f, s) == CMP_GREATER) v.status = STATUS_ORDER;
        else if (rule_total >= Slots) v.status = STATUS_FULL;
        else push_rule(KIND_RANGE, f, s, 8'd0);
      end
      FUNC_SUBNET: begin
        if (c.plen > (c.ffam ? V6PrefixMax : V4PrefixMax)) v.status = STATUS_PREFIX;
        else if (rule_total >= Slots) v.status = STATUS_FULL;
        else push_rule(KIND_SUBNET, f, none, c.plen);
      end
      FUNC_REMOVE: begin
        for (int k = rule_total - 1; k >= 0; k--) begin
          if (tbl_kind[k] == KIND_ADDR && tbl_first[k] == f) begin
            for (int j = k; j < rule_total - 1; j++) begin
              tbl_kind[j]   = tbl_kind[j+1];
              tbl_first[j]  = tbl_first[j+1];
              tbl_second[j] = tbl_second[j+1];
              tbl_prefix[j] = tbl_prefix[j+1];
            end
            rule_total--;
            break;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // most addresses drawn from a small pool so rules and checks collide often
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c.ffam = 1'($urandom_range(0, 1));
    c.sfam = 1'($urandom_range(0, 1));
    c.fhi  = rand64();
    c.flo  = rand64();
    c.shi  = rand64();
    c.slo  = rand64();
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      c.fhi = (pick < 3) ? 64'd0 : {48'h2001_0db8_0000, 16'($urandom_range(0, 3))};
      c.flo = (pick < 3) ? {32'h0000_ffff, 24'h0a0000, 8'($urandom_range(0, 15))}
                         : {$urandom(), 24'h0a0000, 8'($urandom_range(0, 15))};
      c.shi = c.fhi;
      c.slo = c.flo + 64'($urandom_range(0, 40));
    end
    c.plen = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 130));
    pick = $urandom_range(0, 99);
    if (pick < 40) c.func = FUNC_CHECK;
    else if (pick < 55) c.func = FUNC_ADDR;
    else if (pick < 67) c.func = FUNC_RANGE;
    else if (pick < 79) c.func = FUNC_SUBNET;
    else if (pick < 96) c.func = FUNC_REMOVE;
    else c.func = 3'($urandom_range(5, 7));
    c.has_exp = 1'b0;
    c.exp_blocked = 1'b0;
    c.exp_status = STATUS_OK;
    return c;
  endfunction

  function automatic cmd_t row(logic [2:0] fn, logic ff, logic [63:0] fh, logic [63:0] fl,
                               logic sf, logic [63:0] sh, logic [63:0] sl,
                               logic [7:0] p, logic he, logic eb, status_e es);
    cmd_t c;
    c.func = fn; c.ffam = ff; c.fhi = fh; c.flo = fl;
    c.sfam = sf; c.shi = sh; c.slo = sl; c.plen = p;
    c.has_exp = he; c.exp_blocked = eb; c.exp_status = es;
    return c;
  endfunction

  // send one beat and hold it until accepted
  task automatic send_beat(cmd_t c);
    verdict_t v;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    v = block_list_verdict(c);
    if (c.has_exp && (v.blocked != c.exp_blocked || v.status != c.exp_status))
      $display("table row predicted %0d/%0d, typed %0d/%0d",
               v.blocked, v.status, c.exp_blocked, c.exp_status);
    if (c.has_exp) begin
      v.blocked = c.exp_blocked;
      v.status  = c.exp_status;
    end
    pending_verdicts = {pending_verdicts, v};
    in_valid_i      <= 1'b1;
    func_i          <= c.func;
    first_family_i  <= c.ffam;
    first_hi_i      <= c.fhi;
    first_lo_i      <= c.flo;
    second_family_i <= c.sfam;
    second_hi_i     <= c.shi;
    second_lo_i     <= c.slo;
    prefix_len_i    <= c.plen;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stall the result channel and check every beat
  always @(posedge clk_i) begin
    verdict_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat");
        end else begin
          w = pending_verdicts.pop_front();
          if (blocked_o !== w.blocked || status_o !== w.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: blocked exp %0d got %0d, status exp %0d got %0d",
                       w.blocked, blocked_o, w.status, status_o);
          end
        end
      end
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    int          wait_cycles;
    logic [63:0] v6a;
    cmd_t        c;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_CHECK;
    first_family_i = 1'b0;
    first_hi_i = '0;
    first_lo_i = '0;
    second_family_i = 1'b0;
    second_hi_i = '0;
    second_lo_i = '0;
    prefix_len_i = '0;
    rule_total = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    v6a = 64'h2001_0db8_0000_0001;

    // empty table, extremes, refusals, prefix zero, mapped match, remove
    queue_row(row(FUNC_CHECK, 1, '1, '1, 0, 0, 0, 0, 1, 0, STATUS_OK));
    queue_row(row(FUNC_SUBNET, 0, 0, 64'h1, 0, 0, 0, 8'd33, 1, 0, STATUS_PREFIX));
    queue_row(row(FUNC_SUBNET, 1, 0, 0, 0, 0, 0, 8'd129, 1, 0, STATUS_PREFIX));
    queue_row(row(FUNC_SUBNET, 1, 0, 0, 0, 0, 0, 8'd255, 1, 0, STATUS_PREFIX));
    queue_row(row(FUNC_RANGE, 0, 0, 64'h20, 0, 0, 64'h10, 0, 1, 0, STATUS_ORDER));
    queue_row(row(FUNC_REMOVE, 0, 0, 64'h5, 0, 0, 0, 0, 1, 0, STATUS_OK));
    queue_row(row(3'd7, 1, '1, '1, 1, '1, '1, '1, 1, 0, STATUS_OK));
    queue_row(row(FUNC_ADDR, 0, '1, 64'hdead_beef_c0a8_0001, 0, 0, 0, 0,
                  1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 1, 0, 64'h0000_ffff_c0a8_0001, 0, 0, 0, 0,
                  0, 0, STATUS_OK));
    queue_row(row(FUNC_RANGE, 0, 0, 64'h0a00_0000, 1, v6a, 0, 0,
                  1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 0, 0, 64'h0a00_0005, 0, 0, 0, 0, 0, 0, STATUS_OK));
    queue_row(row(FUNC_RANGE, 1, 0, 64'h0000_ffff_0000_0000, 0, 0, '1, 0,
                  1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 0, 0, 64'h7, 0, 0, 0, 0, 0, 0, STATUS_OK));
    queue_row(row(FUNC_SUBNET, 1, v6a, 0, 0, 0, 0, 8'd128, 1, 0, STATUS_OK));
    queue_row(row(FUNC_SUBNET, 0, 0, 64'hc0a8_0000, 0, 0, 0, 8'd32,
                  1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 1, v6a, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
    queue_row(row(FUNC_SUBNET, 0, 0, 0, 0, 0, 0, 8'd0, 1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 1, 0, 64'h0000_ffff_0102_0304, 0, 0, 0, 0,
                  0, 0, STATUS_OK));
    queue_row(row(FUNC_REMOVE, 0, 0, 64'hc0a8_0001, 0, 0, 0, 0,
                  1, 0, STATUS_OK));
    queue_row(row(FUNC_SUBNET, 1, 0, 0, 0, 0, 0, 8'd0, 1, 0, STATUS_OK));
    queue_row(row(FUNC_CHECK, 1, '1, '1, 0, 0, 0, 0, 1, 1, STATUS_OK));
    for (int i = 0; i < 11; i++)
      queue_row(row(FUNC_ADDR, 1, 64'(i), 64'(i), 0, 0, 0, 0,
                    0, 0, STATUS_OK));
    queue_row(row(FUNC_ADDR, 0, 0, 0, 0, 0, 0, 0, 1, 0, STATUS_FULL));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    // drop the address rules added above to start the random part lighter
    for (int i = 0; i < 11; i++)
      send_beat(row(FUNC_REMOVE, 1, 64'(i), 64'(i), 0, 0, 0, 0, 0, 0, STATUS_OK));

    for (int n = 0; n < NumRandom; n++) begin
      case ((n * 5) / NumRandom)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      c = random_cmd();
      send_beat(c);
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_verdicts.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (80) @(posedge clk_i);
    if (pending_verdicts.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ipbl_pkg.sv
rtl/ipbl_ram.sv
rtl/ipbl_match.sv
rtl/ip_address_block_list_matcher_unit.sv
tb/sv/ip_address_block_list_matcher_unit_test.sv
